### rtl/core/csr_sparse_matvec_unit_assert.svh
// Assertion macros for the sparse matrix-vector unit.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef CSR_SPARSE_MATVEC_UNIT_ASSERT_SVH
`define CSR_SPARSE_MATVEC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CSMV_ASSERT_SAME(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("same-cycle check failed");
`define CSMV_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define CSMV_ASSERT_SAME(lbl, clk, rstn, a, c)
`define CSMV_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif

`endif

### rtl/core/csmv_pkg.sv
package csmv_pkg;

    localparam int VECTOR_DEPTH  = 1024;
    localparam int ADDR_W        = $clog2(VECTOR_DEPTH);
    localparam int FRACTION_BITS = 16;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 48;
    localparam int ACC_LO_W  = ACC_W - DATA_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int MLO_W     = DATA_W + ACC_LO_W + 1;
    localparam int AA_W      = DATA_W + ACC_W;
    localparam int SUM_W     = AA_W + 1;

    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 32;

    localparam int IDX_LSB   = 0;
    localparam int VALUE_LSB = IDX_LSB + INDEX_W;
    localparam int PRIOR_LSB = VALUE_LSB + DATA_W;

    localparam logic [KIND_W-1:0] KIND_LOAD      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONZERO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY_ROW = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_SCALED_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_ALPHA = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_BETA  = 2'd2;

    localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] BETA_RESET  = 32'h0000_0000;

    localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

### rtl/core/csr_sparse_matvec_unit.sv
// Sparse matrix times dense vector, CSR order, one request per cycle sustained unless a stalled output backs up.
// Path: a row-closing request passes every pipeline stage and the output register before it shows on m_tvalid.
// Throughput: 1 request per cycle, set by the registered row accumulate and
// the one-read-port vector RAM; a stalled output stops the input once four row
// results wait, a further row-closing request sits at the accumulator and stage 1 is full.
// Reset: clears pipeline valids, output, accumulator and registers to defaults;
// the vector RAM keeps its contents and takes no clearing pass.
`include "csr_sparse_matvec_unit_assert.svh"

module csr_sparse_matvec_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // index [9:0], value [41:10], prior_result [73:42], zero fill [79:74]
    input  logic [csmv_pkg::S_TDATA_W-1:0]        s_tdata,
    // kind [1:0]
    input  logic [csmv_pkg::KIND_W-1:0]           s_tuser,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // row_result [31:0]
    output logic [csmv_pkg::M_TDATA_W-1:0]        m_tdata,
    // saturated [0]
    output logic                                  m_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [csmv_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [csmv_pkg::DATA_W-1:0]           cfg_wdata
);

    localparam int F = csmv_pkg::FRACTION_BITS;

    // configuration
    logic                            mode_reg;
    logic [csmv_pkg::DATA_W-1:0]     alpha_reg;
    logic [csmv_pkg::DATA_W-1:0]     beta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            alpha_reg <= csmv_pkg::ALPHA_RESET;
            beta_reg  <= csmv_pkg::BETA_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                csmv_pkg::REG_SCALED_MODE: mode_reg  <= cfg_wdata[0];
                csmv_pkg::REG_SCALE_ALPHA: alpha_reg <= cfg_wdata;
                csmv_pkg::REG_SCALE_BETA:  beta_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // request decode
    logic [csmv_pkg::INDEX_W-1:0] in_index;
    logic [csmv_pkg::DATA_W-1:0]  in_value;
    logic [csmv_pkg::DATA_W-1:0]  in_prior;
    logic [31:0]                  idx_ext;
    logic                         in_range;
    logic [csmv_pkg::ADDR_W-1:0]  addr;
    logic                         s_accept;
    logic                         is_load;
    logic                         is_nz;
    logic                         is_empty;

    assign in_index = s_tdata[csmv_pkg::IDX_LSB +: csmv_pkg::INDEX_W];
    assign in_value = s_tdata[csmv_pkg::VALUE_LSB +: csmv_pkg::DATA_W];
    assign in_prior = s_tdata[csmv_pkg::PRIOR_LSB +: csmv_pkg::DATA_W];
    assign idx_ext  = 32'(in_index);
    assign in_range = idx_ext < 32'(csmv_pkg::VECTOR_DEPTH);
    assign addr     = idx_ext[csmv_pkg::ADDR_W-1:0];
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        is_load  = 1'b0;
        is_nz    = 1'b0;
        is_empty = 1'b0;
        case (s_tuser)
            csmv_pkg::KIND_LOAD:      is_load  = 1'b1;
            csmv_pkg::KIND_NONZERO:   is_nz    = 1'b1;
            csmv_pkg::KIND_EMPTY_ROW: is_empty = 1'b1;
            default: ;
        endcase
    end

    // pipeline flow: a stage takes new contents when it is empty or its contents leave
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic s2_close_reg;
    logic free_out, free1, free2, free3, free4, free5;
    logic adv1, adv2, adv3, adv4, adv5;

    assign free_out = !out_valid_reg || m_tready;
    assign adv5     = s5_valid_reg && free_out;
    assign free5    = !s5_valid_reg || free_out;
    assign adv4     = s4_valid_reg && free5;
    assign free4    = !s4_valid_reg || free5;
    assign adv3     = s3_valid_reg && free4;
    assign free3    = !s3_valid_reg || free4;
    // a request that leaves the row open ends at the accumulator
    assign adv2     = s2_valid_reg && (!s2_close_reg || free3);
    assign free2    = !s2_valid_reg || adv2;
    assign adv1     = s1_valid_reg && free2;
    assign free1    = !s1_valid_reg || free2;
    assign s_tready = free1;

    // vector RAM: a load writes at acceptance, so a read in the next cycle sees it
    logic [csmv_pkg::DATA_W-1:0] vec_mem [csmv_pkg::VECTOR_DEPTH];
    logic [csmv_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (s_accept && is_load && in_range) begin
            vec_mem[addr] <= in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (free1) begin
            rd_data_reg <= vec_mem[addr];
        end
    end

    // stage 1: vector entry available, form the product
    logic                        s1_use_reg;
    logic                        s1_close_reg;
    logic [csmv_pkg::DATA_W-1:0] s1_prior_reg;
    logic [csmv_pkg::DATA_W-1:0] s1_value_reg;
    logic [csmv_pkg::DATA_W-1:0] s1_x;
    logic signed [csmv_pkg::PROD_W-1:0] s1_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (free1) begin
            s1_valid_reg <= s_accept && (is_nz || is_empty);
        end
    end

    always_ff @(posedge aclk) begin
        if (free1) begin
            s1_use_reg   <= is_nz && in_range;
            s1_close_reg <= is_empty || (is_nz && s_tlast);
            s1_value_reg <= in_value;
            s1_prior_reg <= in_prior;
        end
    end

    // empty rows and out-of-range columns contribute nothing
    assign s1_x    = s1_use_reg ? rd_data_reg : '0;
    assign s1_prod = $signed(s1_value_reg) * $signed(s1_x);

    // stage 2: scale product and accumulate
    logic signed [csmv_pkg::PROD_W-1:0] s2_prod_reg;
    logic [csmv_pkg::DATA_W-1:0]        s2_prior_reg;
    logic signed [csmv_pkg::PROD_W-1:0] s2_shift;
    logic [csmv_pkg::ACC_W-1:0]         s2_p48;
    logic [csmv_pkg::ACC_W:0]           s2_sum_wide;
    logic [csmv_pkg::ACC_W-1:0]         s2_sum;
    logic [csmv_pkg::ACC_W-1:0]         acc_reg;
    logic [csmv_pkg::ACC_W-1:0]         acc_next;
    logic                               s2_fits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (free2) begin
            s2_valid_reg <= adv1;
        end
    end

    always_ff @(posedge aclk) begin
        if (free2) begin
            s2_prod_reg  <= s1_prod;
            s2_close_reg <= s1_close_reg;
            s2_prior_reg <= s1_prior_reg;
        end
    end

    assign s2_shift = s2_prod_reg >>> F;
    assign s2_fits  = (&s2_shift[csmv_pkg::PROD_W-1:csmv_pkg::ACC_W-1])
                   || !(|s2_shift[csmv_pkg::PROD_W-1:csmv_pkg::ACC_W-1]);

    always_comb begin
        if (s2_fits) begin
            s2_p48 = s2_shift[csmv_pkg::ACC_W-1:0];
        end else begin
            s2_p48 = s2_shift[csmv_pkg::PROD_W-1] ? csmv_pkg::ACC_MIN : csmv_pkg::ACC_MAX;
        end
        s2_sum_wide = {acc_reg[csmv_pkg::ACC_W-1], acc_reg}
                    + {s2_p48[csmv_pkg::ACC_W-1], s2_p48};
        if (s2_sum_wide[csmv_pkg::ACC_W] != s2_sum_wide[csmv_pkg::ACC_W-1]) begin
            s2_sum = s2_sum_wide[csmv_pkg::ACC_W] ? csmv_pkg::ACC_MIN : csmv_pkg::ACC_MAX;
        end else begin
            s2_sum = s2_sum_wide[csmv_pkg::ACC_W-1:0];
        end
        acc_next = acc_reg;
        if (adv2) begin
            acc_next = s2_close_reg ? '0 : s2_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // stage 3: closed row value, split multiplies for the scaled form
    logic [csmv_pkg::ACC_W-1:0]          s3_acc_reg;
    logic [csmv_pkg::DATA_W-1:0]         s3_prior_reg;
    logic signed [csmv_pkg::PROD_W-1:0]  s3_mhi;
    logic signed [csmv_pkg::MLO_W-1:0]   s3_mlo;
    logic signed [csmv_pkg::PROD_W-1:0]  s3_mb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (free3) begin
            s3_valid_reg <= adv2 && s2_close_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (free3) begin
            s3_acc_reg   <= s2_sum;
            s3_prior_reg <= s2_prior_reg;
        end
    end

    assign s3_mhi = $signed(alpha_reg)
                  * $signed(s3_acc_reg[csmv_pkg::ACC_W-1:csmv_pkg::ACC_LO_W]);
    assign s3_mlo = $signed(alpha_reg)
                  * $signed({1'b0, s3_acc_reg[csmv_pkg::ACC_LO_W-1:0]});
    assign s3_mb  = $signed(beta_reg) * $signed(s3_prior_reg);

    // stage 4: recombine alpha times accumulator
    logic signed [csmv_pkg::PROD_W-1:0] s4_mhi_reg;
    logic signed [csmv_pkg::MLO_W-1:0]  s4_mlo_reg;
    logic signed [csmv_pkg::PROD_W-1:0] s4_mb_reg;
    logic [csmv_pkg::ACC_W-1:0]         s4_acc_reg;
    logic signed [csmv_pkg::AA_W-1:0]   s4_aa;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (free4) begin
            s4_valid_reg <= adv3;
        end
    end

    always_ff @(posedge aclk) begin
        if (free4) begin
            s4_mhi_reg <= s3_mhi;
            s4_mlo_reg <= s3_mlo;
            s4_mb_reg  <= s3_mb;
            s4_acc_reg <= s3_acc_reg;
        end
    end

    assign s4_aa = (csmv_pkg::AA_W'(s4_mhi_reg) <<< csmv_pkg::ACC_LO_W)
                 + csmv_pkg::AA_W'(s4_mlo_reg);

    // stage 5: in scaled mode add beta term, rescale and clamp; otherwise clamp the accumulator
    logic signed [csmv_pkg::AA_W-1:0]   s5_aa_reg;
    logic signed [csmv_pkg::PROD_W-1:0] s5_mb_reg;
    logic [csmv_pkg::ACC_W-1:0]         s5_acc_reg;
    logic signed [csmv_pkg::SUM_W-1:0]  s5_total;
    logic signed [csmv_pkg::SUM_W-1:0]  s5_shift;
    logic [csmv_pkg::DATA_W-1:0]        s5_result;
    logic                               s5_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (free5) begin
            s5_valid_reg <= adv4;
        end
    end

    always_ff @(posedge aclk) begin
        if (free5) begin
            s5_aa_reg  <= s4_aa;
            s5_mb_reg  <= s4_mb_reg;
            s5_acc_reg <= s4_acc_reg;
        end
    end

    assign s5_total = csmv_pkg::SUM_W'(s5_aa_reg) + csmv_pkg::SUM_W'(s5_mb_reg);
    assign s5_shift = s5_total >>> F;

    always_comb begin
        if (mode_reg) begin
            s5_sat = !((&s5_shift[csmv_pkg::SUM_W-1:csmv_pkg::DATA_W-1])
                    || !(|s5_shift[csmv_pkg::SUM_W-1:csmv_pkg::DATA_W-1]));
            if (s5_sat) begin
                s5_result = s5_shift[csmv_pkg::SUM_W-1] ? csmv_pkg::DATA_MIN
                                                         : csmv_pkg::DATA_MAX;
            end else begin
                s5_result = s5_shift[csmv_pkg::DATA_W-1:0];
            end
        end else begin
            s5_sat = !((&s5_acc_reg[csmv_pkg::ACC_W-1:csmv_pkg::DATA_W-1])
                    || !(|s5_acc_reg[csmv_pkg::ACC_W-1:csmv_pkg::DATA_W-1]));
            if (s5_sat) begin
                s5_result = s5_acc_reg[csmv_pkg::ACC_W-1] ? csmv_pkg::DATA_MIN
                                                           : csmv_pkg::DATA_MAX;
            end else begin
                s5_result = s5_acc_reg[csmv_pkg::DATA_W-1:0];
            end
        end
    end

    // output register
    logic [csmv_pkg::DATA_W-1:0] out_data_reg;
    logic                        out_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (free_out) begin
            out_valid_reg <= adv5;
        end
    end

    always_ff @(posedge aclk) begin
        if (free_out) begin
            out_data_reg <= s5_result;
            out_sat_reg  <= s5_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

    // a closed row restarts from zero
    `CSMV_ASSERT_NEXT(a_acc_clear, aclk, aresetn, adv2 && s2_close_reg, acc_reg == '0)
    // the accumulator moves only when stage 2 hands its request on
    `CSMV_ASSERT_NEXT(a_acc_hold, aclk, aresetn, !adv2, $stable(acc_reg))
    // nonzero and empty-row requests always enter the pipeline
    `CSMV_ASSERT_NEXT(a_s1_entry, aclk, aresetn, s_accept && (is_nz || is_empty), s1_valid_reg)
    // a blocked final stage keeps its row value
    `CSMV_ASSERT_NEXT(a_s5_hold, aclk, aresetn, s5_valid_reg && !free_out,
                      s5_valid_reg && $stable(s5_acc_reg) && $stable(s5_aa_reg))
    // the input is ready whenever stage 1 is empty
    `CSMV_ASSERT_SAME(a_ready_free, aclk, aresetn, !s1_valid_reg, s_tready)

endmodule

### bench/csr_sparse_matvec_checker.sv
module csr_sparse_matvec_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    // index [9:0], value [41:10], prior_result [73:42], zero fill [79:74]
    input  logic [csmv_pkg::S_TDATA_W-1:0]        s_tdata,
    // kind [1:0]
    input  logic [csmv_pkg::KIND_W-1:0]           s_tuser,
    input  logic                                  s_tlast,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    // row_result [31:0]
    input  logic [csmv_pkg::M_TDATA_W-1:0]        m_tdata,
    // saturated [0]
    input  logic                                  m_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [csmv_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [csmv_pkg::DATA_W-1:0]           cfg_wdata,
    output int                                    fail_count,
    output int                                    rows_due,
    output int                                    rows_checked
);

    typedef struct packed {
        logic [csmv_pkg::DATA_W-1:0] row_result;
        logic                        saturated;
    } row_out_t;

    row_out_t                           row_results_due[$];
    logic [csmv_pkg::DATA_W-1:0]        vector_copy [csmv_pkg::VECTOR_DEPTH];
    logic signed [csmv_pkg::ACC_W-1:0]  row_sum;
    logic                               scaled;
    logic signed [csmv_pkg::DATA_W-1:0] alpha;
    logic signed [csmv_pkg::DATA_W-1:0] beta;
    int                                 err_total = 0;
    int                                 checked_total = 0;

    // Clip a wide signed value to a signed range of the given width.
    function automatic logic signed [63:0] clip(input logic signed [127:0] x,
                                                input int bits, output logic sat);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (bits - 1)) - 128'sd1;
        lo_lim = -hi_lim - 128'sd1;
        sat = 1'b0;
        if (x > hi_lim) begin
            sat = 1'b1;
            return hi_lim[63:0];
        end
        if (x < lo_lim) begin
            sat = 1'b1;
            return lo_lim[63:0];
        end
        return x[63:0];
    endfunction

    function automatic void add_product(input logic [csmv_pkg::INDEX_W-1:0] col,
                                        input logic signed [csmv_pkg::DATA_W-1:0] val);
        logic signed [csmv_pkg::DATA_W-1:0] entry;
        logic signed [127:0]      prod;
        logic signed [127:0]      val_w;
        logic signed [127:0]      sum_w;
        logic signed [127:0]      acc_w;
        logic signed [63:0]       part;
        logic signed [63:0]       clipped;
        logic                     s;
        entry = vector_copy[col];
        prod  = entry;
        val_w = val;
        // exact product, then floor shift back to the accumulator's scale
        prod  = (prod * val_w) >>> csmv_pkg::FRACTION_BITS;
        part  = clip(prod, csmv_pkg::ACC_W, s);
        acc_w = row_sum;
        sum_w = part;
        sum_w = sum_w + acc_w;
        clipped = clip(sum_w, csmv_pkg::ACC_W, s);
        row_sum = clipped[csmv_pkg::ACC_W-1:0];
    endfunction

    function automatic row_out_t row_total(input logic signed [csmv_pkg::DATA_W-1:0] prior);
        logic signed [127:0] t;
        logic signed [127:0] a_w;
        logic signed [127:0] b_w;
        logic signed [127:0] p_w;
        logic signed [127:0] acc_w;
        logic signed [63:0]  r;
        logic                sat;
        row_out_t            o;
        acc_w = row_sum;
        if (scaled) begin
            a_w = alpha;
            b_w = beta;
            p_w = prior;
            t = (a_w * acc_w + b_w * p_w) >>> csmv_pkg::FRACTION_BITS;
            r = clip(t, csmv_pkg::DATA_W, sat);
        end else begin
            r = clip(acc_w, csmv_pkg::DATA_W, sat);
        end
        row_sum = '0;
        o.row_result = r[csmv_pkg::DATA_W-1:0];
        o.saturated  = sat;
        return o;
    endfunction

    always @(posedge aclk) begin
        row_out_t got;
        row_out_t want;
        if (!aresetn) begin
            row_sum = '0;
            scaled  = 1'b0;
            alpha   = csmv_pkg::ALPHA_RESET;
            beta    = csmv_pkg::BETA_RESET;
            row_results_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    csmv_pkg::REG_SCALED_MODE: scaled = cfg_wdata[0];
                    csmv_pkg::REG_SCALE_ALPHA: alpha  = cfg_wdata;
                    csmv_pkg::REG_SCALE_BETA:  beta   = cfg_wdata;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.row_result = m_tdata;
                got.saturated  = m_tuser;
                if (row_results_due.size() == 0) begin
                    $error("row_result: expected none, actual %h (saturated %b)",
                           got.row_result, got.saturated);
                    err_total++;
                end else begin
                    want = row_results_due.pop_front();
                    checked_total++;
                    if (got.row_result !== want.row_result) begin
                        $error("row_result: expected %h, actual %h",
                               want.row_result, got.row_result);
                        err_total++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $error("saturated: expected %b, actual %b",
                               want.saturated, got.saturated);
                        err_total++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    csmv_pkg::KIND_LOAD:
                        vector_copy[s_tdata[csmv_pkg::IDX_LSB +: csmv_pkg::INDEX_W]] =
                            s_tdata[csmv_pkg::VALUE_LSB +: csmv_pkg::DATA_W];
                    csmv_pkg::KIND_NONZERO: begin
                        add_product(s_tdata[csmv_pkg::IDX_LSB +: csmv_pkg::INDEX_W],
                                    s_tdata[csmv_pkg::VALUE_LSB +: csmv_pkg::DATA_W]);
                        if (s_tlast)
                            row_results_due.push_back(
                                row_total(s_tdata[csmv_pkg::PRIOR_LSB +: csmv_pkg::DATA_W]));
                    end
                    csmv_pkg::KIND_EMPTY_ROW:
                        row_results_due.push_back(
                            row_total(s_tdata[csmv_pkg::PRIOR_LSB +: csmv_pkg::DATA_W]));
                    default: ;
                endcase
            end
        end
        fail_count   <= err_total;
        rows_due     <= row_results_due.size();
        rows_checked <= checked_total;
    end

endmodule

### bench/csr_sparse_matvec_unit_test.sv
module csr_sparse_matvec_unit_test;

    localparam logic [csmv_pkg::KIND_W-1:0]      KIND_UNUSED = 2'd3;
    localparam logic [csmv_pkg::CFG_INDEX_W-1:0] REG_NONE    = 2'd3;
    localparam int                               CYCLE_LIMIT = 300000;
    localparam int                               PHASES      = 8;
    localparam int                               PHASE_ITEMS = 110;

    logic                                  aclk      = 1'b0;
    logic                                  aresetn   = 1'b0;
    logic                                  s_tvalid  = 1'b0;
    logic                                  s_tready;
    logic [csmv_pkg::S_TDATA_W-1:0]        s_tdata   = '0;
    logic [csmv_pkg::KIND_W-1:0]           s_tuser   = csmv_pkg::KIND_LOAD;
    logic                                  s_tlast   = 1'b0;
    logic                                  m_tvalid;
    logic                                  m_tready  = 1'b0;
    logic [csmv_pkg::M_TDATA_W-1:0]        m_tdata;
    logic                                  m_tuser;
    logic                                  cfg_wr_en = 1'b0;
    logic [csmv_pkg::CFG_INDEX_W-1:0]      cfg_index = csmv_pkg::REG_SCALED_MODE;
    logic [csmv_pkg::DATA_W-1:0]           cfg_wdata = '0;

    int fail_count;
    int rows_due;
    int rows_checked;
    int cycle_count = 0;
    int burst_left  = 0;
    int n_loads     = 0;
    int n_nonzeros  = 0;
    int n_empty     = 0;
    int n_ignored   = 0;
    int rx_mode     = 0;
    int rx_span     = 0;
    int rx_tick     = 0;

    bit                           written [csmv_pkg::VECTOR_DEPTH];
    logic [csmv_pkg::INDEX_W-1:0] written_list[$];
    bit                           row_open = 1'b0;

    csr_sparse_matvec_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    csr_sparse_matvec_checker row_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .rows_due     (rows_due),
        .rows_checked (rows_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: switch between always ready, random, periodic and long stalls.
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_span = $urandom_range(16, 96);
        end
        rx_span--;
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((rx_tick % 7) < 3);
            default: m_tready <= ((rx_tick % 32) >= 24);
        endcase
    end

    // Mostly small Q16.16 values, with the range ends and full-width noise mixed in.
    function automatic logic [csmv_pkg::DATA_W-1:0] pick_q16();
        case ($urandom_range(0, 7))
            0:       return csmv_pkg::DATA_MAX;
            1:       return csmv_pkg::DATA_MIN;
            2:       return $urandom();
            default: return $urandom_range(0, 32'h7ffff) - 32'h40000;
        endcase
    endfunction

    task automatic send_item(input logic [csmv_pkg::KIND_W-1:0] kind,
                             input logic [csmv_pkg::INDEX_W-1:0] idx,
                             input logic [csmv_pkg::DATA_W-1:0] val, input logic last,
                             input logic [csmv_pkg::DATA_W-1:0] prior);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {6'd0, prior, val, idx};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        case (kind)
            csmv_pkg::KIND_LOAD:    n_loads++;
            csmv_pkg::KIND_NONZERO: begin
                n_nonzeros++;
                row_open = !last;
            end
            csmv_pkg::KIND_EMPTY_ROW: begin
                n_empty++;
                row_open = 1'b0;
            end
            default:      n_ignored++;
        endcase
    endtask

    task automatic load_entry(input logic [csmv_pkg::INDEX_W-1:0] idx,
                              input logic [csmv_pkg::DATA_W-1:0] val);
        send_item(csmv_pkg::KIND_LOAD, idx, val, 1'($urandom_range(0, 1)), $urandom());
        if (!written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
        end
    endtask

    task automatic nonzero(input logic [csmv_pkg::INDEX_W-1:0] col,
                           input logic [csmv_pkg::DATA_W-1:0] val, input logic last);
        send_item(csmv_pkg::KIND_NONZERO, col, val, last, pick_q16());
    endtask

    // Drop valid, wait until every row result is in, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (rows_due != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_regs(input logic mode, input logic [csmv_pkg::DATA_W-1:0] alpha,
                              input logic [csmv_pkg::DATA_W-1:0] beta);
        logic [csmv_pkg::DATA_W-1:0] junk;
        junk = $urandom();
        cfg_wr_en <= 1'b1;
        cfg_index <= csmv_pkg::REG_SCALED_MODE;
        cfg_wdata <= {junk[csmv_pkg::DATA_W-1:1], mode};
        @(posedge aclk);
        cfg_index <= csmv_pkg::REG_SCALE_ALPHA;
        cfg_wdata <= alpha;
        @(posedge aclk);
        cfg_index <= csmv_pkg::REG_SCALE_BETA;
        cfg_wdata <= beta;
        @(posedge aclk);
        // an index past the register list must change nothing
        cfg_index <= REG_NONE;
        cfg_wdata <= $urandom();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_requests();
        load_entry(10'd0, csmv_pkg::DATA_MAX);
        load_entry(10'd1023, csmv_pkg::DATA_MIN);
        load_entry(10'd1, 32'h0001_0000);
        load_entry(10'd512, 32'h0002_8000);
        nonzero(10'd1, 32'h0003_0000, 1'b1);
        // three near-full products push the accumulator past its range
        nonzero(10'd0, csmv_pkg::DATA_MAX, 1'b0);
        nonzero(10'd0, csmv_pkg::DATA_MAX, 1'b0);
        nonzero(10'd0, csmv_pkg::DATA_MAX, 1'b1);
        nonzero(10'd1023, csmv_pkg::DATA_MIN, 1'b1);
        nonzero(10'd1023, csmv_pkg::DATA_MAX, 1'b1);
        // negative products; the second one needs floor rounding
        nonzero(10'd1023, 32'h0000_0001, 1'b1);
        nonzero(10'd512, 32'hffff_ffff, 1'b1);
        send_item(csmv_pkg::KIND_EMPTY_ROW, 10'd1023, csmv_pkg::DATA_MIN, 1'b1,
                  csmv_pkg::DATA_MAX);
        // empty row arriving while a row is still open
        nonzero(10'd1, 32'h0001_0000, 1'b0);
        send_item(csmv_pkg::KIND_EMPTY_ROW, 10'd0, 32'h0, 1'b0, csmv_pkg::DATA_MIN);
        nonzero(10'd512, 32'h0000_8000, 1'b0);
        send_item(KIND_UNUSED, 10'h3ff, csmv_pkg::DATA_MAX, 1'b1, csmv_pkg::DATA_MAX);
        // a load mid-row, read back on the very next request
        load_entry(10'd2, 32'h0005_0000);
        nonzero(10'd2, 32'hfffe_0000, 1'b1);
        load_entry(10'd3, 32'h1234_5678);
        nonzero(10'd3, 32'h0000_4000, 1'b1);
    endtask

    task automatic random_requests(input int n);
        int sent;
        int r;
        int len;
        logic [csmv_pkg::INDEX_W-1:0] col;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (written_list.size() == 0 || r < 12) begin
                load_entry(csmv_pkg::INDEX_W'($urandom()), pick_q16());
                sent++;
            end else if (r < 16) begin
                send_item(KIND_UNUSED, csmv_pkg::INDEX_W'($urandom()), $urandom(),
                          1'($urandom_range(0, 1)), $urandom());
            end else if (r < 24) begin
                send_item(csmv_pkg::KIND_EMPTY_ROW, csmv_pkg::INDEX_W'($urandom()),
                          $urandom(), 1'($urandom_range(0, 1)), pick_q16());
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        load_entry(csmv_pkg::INDEX_W'($urandom()), pick_q16());
                        sent++;
                    end
                    col = written_list[$urandom_range(0, written_list.size() - 1)];
                    // now and then leave the row unterminated
                    nonzero(col, pick_q16(), (j == len - 1) && ($urandom_range(0, 15) != 0));
                    sent++;
                end
            end
        end
        if (row_open)
            send_item(csmv_pkg::KIND_EMPTY_ROW, csmv_pkg::INDEX_W'($urandom()), $urandom(),
                      1'b1, pick_q16());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                directed_requests();
            end else begin
                drain();
                case (ph)
                    1:       write_regs(1'b0, $urandom(), $urandom());
                    2:       write_regs(1'b1, 32'h0001_0000, 32'h0001_0000);
                    3:       write_regs(1'b1, csmv_pkg::DATA_MAX, csmv_pkg::DATA_MIN);
                    4:       write_regs(1'b1, csmv_pkg::DATA_MIN, csmv_pkg::DATA_MAX);
                    5:       write_regs(1'b1, 32'h0, $urandom());
                    6:       write_regs(1'b1, $urandom(), pick_q16());
                    default: write_regs(1'b0, csmv_pkg::ALPHA_RESET, csmv_pkg::BETA_RESET);
                endcase
            end
            random_requests(PHASE_ITEMS);
        end
        drain();
        $display("Sent %0d loads, %0d nonzeros, %0d empty rows, %0d unused-kind requests",
                 n_loads, n_nonzeros, n_empty, n_ignored);
        $display("across %0d register settings; %0d row results compared",
                 PHASES, rows_checked);
        if (fail_count == 0 && rows_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### csr_sparse_matvec_unit.f
+incdir+rtl/core
rtl/core/csmv_pkg.sv
rtl/core/csr_sparse_matvec_unit.sv
bench/csr_sparse_matvec_checker.sv
bench/csr_sparse_matvec_unit_test.sv
